### src/tsfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsfr_pkg
// Types and constants shared by the typed sensor frame receiver.
// ----------------------------------------------------------------------------
package tsfr_pkg;

	localparam int FRAME_LEN  = 14;
	localparam int WORD_COUNT = 7;

	typedef logic [3:0] pos_t;
	typedef logic [FRAME_LEN-1:0][7:0]   frame_t;
	typedef logic [WORD_COUNT-1:0][15:0] words_t;

	typedef struct packed {
		logic [7:0] code_status;
		logic [7:0] code_raw;
		logic [7:0] code_threshold;
		logic [7:0] code_colour;
	} codes_t;

	localparam pos_t POS_IDLE   = 4'd0;
	localparam pos_t POS_FIRST  = 4'd1;
	localparam pos_t POS_TYPE   = 4'd2;
	localparam pos_t POS_LEN_A  = 4'd4;
	localparam pos_t POS_LEN_B  = 4'd6;
	localparam pos_t POS_LEN_C  = 4'd13;
	localparam pos_t POS_LAST   = 4'd14;
	localparam pos_t POS_UNUSED = 4'd15;

	localparam logic [2:0] REG_HEADER_FIRST   = 3'd0;
	localparam logic [2:0] REG_HEADER_SECOND  = 3'd1;
	localparam logic [2:0] REG_CODE_STATUS    = 3'd2;
	localparam logic [2:0] REG_CODE_RAW       = 3'd3;
	localparam logic [2:0] REG_CODE_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_CODE_COLOUR    = 3'd5;
	localparam logic [2:0] REG_WHITE_STATUS   = 3'd6;
	localparam logic [2:0] REG_WHITE_COLOUR   = 3'd7;

	localparam logic [7:0]  RST_HEADER_FIRST   = 8'd255;
	localparam logic [7:0]  RST_HEADER_SECOND  = 8'd254;
	localparam logic [7:0]  RST_CODE_STATUS    = 8'd3;
	localparam logic [7:0]  RST_CODE_RAW       = 8'd1;
	localparam logic [7:0]  RST_CODE_THRESHOLD = 8'd4;
	localparam logic [7:0]  RST_CODE_COLOUR    = 8'd2;
	localparam logic [15:0] RST_WHITE_STATUS   = 16'd1;
	localparam logic [15:0] RST_WHITE_COLOUR   = 16'd1;

endpackage
`default_nettype wire

### src/tsfr_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsfr_decode
// Decodes the frame buffer by its type byte into seven big-endian words.
// ----------------------------------------------------------------------------
module tsfr_decode (
	input  wire tsfr_pkg::frame_t frame,
	input  wire tsfr_pkg::words_t words_in,
	input  wire tsfr_pkg::codes_t codes,
	output tsfr_pkg::words_t      words_out
);

	logic [7:0] frame_type;

	assign frame_type = frame[0];

	always_comb begin
		words_out = words_in;
		if (frame_type == codes.code_raw) begin
			words_out[0] = {frame[1], frame[2]};
			words_out[1] = {frame[3], frame[4]};
			words_out[2] = {8'h00, frame[5]};
		end else if (frame_type == codes.code_colour) begin
			for (int k = 0; k < 6; k++) begin
				words_out[k] = {frame[1 + 2 * k], frame[2 + 2 * k]};
			end
			words_out[6] = {8'h00, frame[13]};
		end else if (frame_type == codes.code_status) begin
			words_out[1] = {8'h00, frame[1]};
		end else if (frame_type == codes.code_threshold) begin
			for (int k = 0; k < 6; k++) begin
				words_out[k + 1] = {frame[1 + 2 * k], frame[2 + 2 * k]};
			end
		end
	end

endmodule
`default_nettype wire

### src/typed_sensor_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// typed_sensor_frame_receiver
// Byte-wise receiver of typed sensor frames with white-line detection.
// ----------------------------------------------------------------------------
// One received byte enters per transaction and one result leaves per
// transaction; a new byte is taken every cycle while results are drained.
// The byte is captured in an input register; when it advances, the frame
// position, buffer and decoded words are updated in one pass and written
// into the result register. Updating the frame position and the 14-byte
// buffer in one pass sets the rate of one byte per cycle while results are
// drained. A register write over the APB-style port takes effect for bytes
// processed after it; write only while no transaction is in flight.
// ----------------------------------------------------------------------------
module typed_sensor_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        follow_enabled,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [15:0] word0,
	output logic      [15:0] word1,
	output logic      [15:0] word2,
	output logic      [15:0] word3,
	output logic      [15:0] word4,
	output logic      [15:0] word5,
	output logic      [15:0] word6,
	output logic             header_seen,
	output logic             white_detect
);

	logic [7:0]  header_first_q;
	logic [7:0]  header_second_q;
	logic [15:0] white_status_q;
	logic [15:0] white_colour_q;
	tsfr_pkg::codes_t codes_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       follow_s1;

	logic             valid_s2;
	tsfr_pkg::words_t words_s2;
	logic             header_s2;
	logic             white_s2;

	tsfr_pkg::pos_t   pos_q;
	logic [7:0]       prev_q;
	tsfr_pkg::frame_t frame_q;

	logic             advance;
	logic             accept;
	logic             in_frame;
	logic             hdr_hit;
	logic [7:0]       type_now;
	tsfr_pkg::pos_t   pos_step;
	tsfr_pkg::pos_t   pos_next;
	tsfr_pkg::frame_t frame_next;
	tsfr_pkg::words_t words_next;
	logic             white_next;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q         <= tsfr_pkg::RST_HEADER_FIRST;
			header_second_q        <= tsfr_pkg::RST_HEADER_SECOND;
			codes_q.code_status    <= tsfr_pkg::RST_CODE_STATUS;
			codes_q.code_raw       <= tsfr_pkg::RST_CODE_RAW;
			codes_q.code_threshold <= tsfr_pkg::RST_CODE_THRESHOLD;
			codes_q.code_colour    <= tsfr_pkg::RST_CODE_COLOUR;
			white_status_q         <= tsfr_pkg::RST_WHITE_STATUS;
			white_colour_q         <= tsfr_pkg::RST_WHITE_COLOUR;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tsfr_pkg::REG_HEADER_FIRST:   header_first_q         <= pwdata[7:0];
				tsfr_pkg::REG_HEADER_SECOND:  header_second_q        <= pwdata[7:0];
				tsfr_pkg::REG_CODE_STATUS:    codes_q.code_status    <= pwdata[7:0];
				tsfr_pkg::REG_CODE_RAW:       codes_q.code_raw       <= pwdata[7:0];
				tsfr_pkg::REG_CODE_THRESHOLD: codes_q.code_threshold <= pwdata[7:0];
				tsfr_pkg::REG_CODE_COLOUR:    codes_q.code_colour    <= pwdata[7:0];
				tsfr_pkg::REG_WHITE_STATUS:   white_status_q         <= pwdata[15:0];
				tsfr_pkg::REG_WHITE_COLOUR:   white_colour_q         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			tsfr_pkg::REG_HEADER_FIRST:   prdata = {24'h0, header_first_q};
			tsfr_pkg::REG_HEADER_SECOND:  prdata = {24'h0, header_second_q};
			tsfr_pkg::REG_CODE_STATUS:    prdata = {24'h0, codes_q.code_status};
			tsfr_pkg::REG_CODE_RAW:       prdata = {24'h0, codes_q.code_raw};
			tsfr_pkg::REG_CODE_THRESHOLD: prdata = {24'h0, codes_q.code_threshold};
			tsfr_pkg::REG_CODE_COLOUR:    prdata = {24'h0, codes_q.code_colour};
			tsfr_pkg::REG_WHITE_STATUS:   prdata = {16'h0, white_status_q};
			tsfr_pkg::REG_WHITE_COLOUR:   prdata = {16'h0, white_colour_q};
			default:                      prdata = 32'h0;
		endcase
	end

	// pipeline handshake
	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & ~advance;
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~advance);
			valid_s2 <= advance | (valid_s2 & result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1   <= rx_byte;
			follow_s1 <= follow_enabled;
		end
	end

	// frame tracking
	assign in_frame = (pos_q >= tsfr_pkg::POS_FIRST) && (pos_q <= tsfr_pkg::POS_LAST);
	assign type_now = (pos_q == tsfr_pkg::POS_FIRST) ? byte_s1 : frame_q[0];
	assign hdr_hit  = (byte_s1 == header_second_q) && (prev_q == header_first_q);

	always_comb begin
		for (int i = 0; i < tsfr_pkg::FRAME_LEN; i++) begin
			frame_next[i] = (in_frame && pos_q == 4'(i + 1)) ? byte_s1 : frame_q[i];
		end
	end

	always_comb begin
		case (pos_q)
			tsfr_pkg::POS_TYPE:
				pos_step = (type_now == codes_q.code_status) ? tsfr_pkg::POS_IDLE : 4'd3;
			tsfr_pkg::POS_LEN_A:
				pos_step = (type_now == codes_q.code_raw ||
					type_now == codes_q.code_threshold ||
					type_now == codes_q.code_colour) ? 4'd5 : tsfr_pkg::POS_IDLE;
			tsfr_pkg::POS_LEN_B:
				pos_step = (type_now == codes_q.code_colour ||
					type_now == codes_q.code_threshold) ? 4'd7 : tsfr_pkg::POS_IDLE;
			tsfr_pkg::POS_LEN_C:
				pos_step = (type_now == codes_q.code_threshold) ?
					tsfr_pkg::POS_IDLE : tsfr_pkg::POS_LAST;
			tsfr_pkg::POS_LAST:
				pos_step = tsfr_pkg::POS_IDLE;
			default:
				pos_step = pos_q + 4'd1;
		endcase
	end

	always_comb begin
		if (hdr_hit) begin
			pos_next = tsfr_pkg::POS_FIRST;
		end else if (in_frame) begin
			pos_next = pos_step;
		end else begin
			pos_next = tsfr_pkg::POS_IDLE;
		end
	end

	tsfr_decode u_decode (
		.frame     (frame_next),
		.words_in  (words_s2),
		.codes     (codes_q),
		.words_out (words_next)
	);

	assign white_next = (words_next[1] == white_status_q) &&
		(words_next[0] != white_colour_q) && follow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= tsfr_pkg::POS_IDLE;
			prev_q    <= 8'h00;
			frame_q   <= '0;
			words_s2  <= '0;
			header_s2 <= 1'b0;
			white_s2  <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_next;
			prev_q    <= byte_s1;
			frame_q   <= frame_next;
			words_s2  <= words_next;
			header_s2 <= hdr_hit;
			white_s2  <= white_next;
		end
	end

	assign result_valid = valid_s2;
	assign word0        = words_s2[0];
	assign word1        = words_s2[1];
	assign word2        = words_s2[2];
	assign word3        = words_s2[3];
	assign word4        = words_s2[4];
	assign word5        = words_s2[5];
	assign word6        = words_s2[6];
	assign header_seen  = header_s2;
	assign white_detect = white_s2;

	a_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != tsfr_pkg::POS_UNUSED)
		else $error("frame position reached unused code");

	a_header_arms: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hdr_hit |=> pos_q == tsfr_pkg::POS_FIRST && header_seen)
		else $error("header did not arm the receiver");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed transaction did not reach the result register");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed sensor frame receiver.
// ----------------------------------------------------------------------------
// Runs a directed byte sequence and then random frame traffic under several
// register settings: reset values, all zero, all ones, and random codes with
// some forced collisions. A clocked driver sends bytes from a queue. A clocked
// monitor checks each result against a local model of the frame position,
// the buffer and the decoded words. Both sides add random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [7:0] data;
		logic       follow;
	} rx_item_t;

	typedef struct packed {
		tsfr_pkg::words_t words;
		logic             seen;
		logic             white;
	} frame_result_t;

	localparam logic [0:24][7:0] DIRECTED = {
		8'h00, 8'hFF, 8'hFF, 8'hFE, 8'h03, 8'h01, 8'hFF, 8'hFE, 8'h01, 8'h12,
		8'h34, 8'hFF, 8'hFE, 8'h77, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 8'hFE, 8'h01,
		8'h00, 8'h01, 8'hFF, 8'hFF, 8'h80
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  rx_byte = '0;
	logic        follow_enabled = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] word0, word1, word2, word3, word4, word5, word6;
	logic        header_seen;
	logic        white_detect;

	// register shadow
	logic [7:0]  hdr_first = tsfr_pkg::RST_HEADER_FIRST;
	logic [7:0]  hdr_second = tsfr_pkg::RST_HEADER_SECOND;
	logic [7:0]  code_st = tsfr_pkg::RST_CODE_STATUS;
	logic [7:0]  code_rw = tsfr_pkg::RST_CODE_RAW;
	logic [7:0]  code_th = tsfr_pkg::RST_CODE_THRESHOLD;
	logic [7:0]  code_co = tsfr_pkg::RST_CODE_COLOUR;
	logic [15:0] white_st = tsfr_pkg::RST_WHITE_STATUS;
	logic [15:0] white_co = tsfr_pkg::RST_WHITE_COLOUR;

	// receiver model state
	tsfr_pkg::pos_t   frame_pos = tsfr_pkg::POS_IDLE;
	logic [7:0]       last_byte = 8'h00;
	logic [7:0]       frame_buf [tsfr_pkg::FRAME_LEN];
	tsfr_pkg::words_t dec_words = '0;

	rx_item_t      byte_queue [$];
	frame_result_t decoded_expect [$];
	int            fail_count = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	logic          src_burst = 1'b0;
	logic          snk_burst = 1'b0;

	typed_sensor_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.rx_byte       (rx_byte),
		.follow_enabled(follow_enabled),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.word0         (word0),
		.word1         (word1),
		.word2         (word2),
		.word3         (word3),
		.word4         (word4),
		.word5         (word5),
		.word6         (word6),
		.header_seen   (header_seen),
		.white_detect  (white_detect)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic tsfr_pkg::pos_t advance_pos(input tsfr_pkg::pos_t pos,
		input logic [7:0] kind);
		case (pos)
			tsfr_pkg::POS_TYPE:
				return (kind == code_st) ? tsfr_pkg::POS_IDLE : tsfr_pkg::pos_t'(3);
			tsfr_pkg::POS_LEN_A: begin
				if (kind == code_rw || kind == code_th || kind == code_co)
					return tsfr_pkg::pos_t'(5);
				return tsfr_pkg::POS_IDLE;
			end
			tsfr_pkg::POS_LEN_B:
				return (kind == code_co || kind == code_th) ?
					tsfr_pkg::pos_t'(7) : tsfr_pkg::POS_IDLE;
			tsfr_pkg::POS_LEN_C:
				return (kind == code_th) ? tsfr_pkg::POS_IDLE : tsfr_pkg::POS_LAST;
			tsfr_pkg::POS_LAST: return tsfr_pkg::POS_IDLE;
			default: return pos + 4'd1;
		endcase
	endfunction

	function automatic logic [15:0] byte_pair(input int hi);
		return {frame_buf[hi], frame_buf[hi+1]};
	endfunction

	function automatic frame_result_t receive_byte(input logic [7:0] b, input logic follow);
		frame_result_t r;
		logic [7:0] kind;
		r.seen = 1'b0;
		if (frame_pos >= tsfr_pkg::POS_FIRST && frame_pos <= tsfr_pkg::POS_LAST) begin
			frame_buf[frame_pos - 4'd1] = b;
			frame_pos = advance_pos(frame_pos, frame_buf[0]);
		end else begin
			frame_pos = tsfr_pkg::POS_IDLE;
		end
		if (b == hdr_second && last_byte == hdr_first) begin
			frame_pos = tsfr_pkg::POS_FIRST;
			r.seen = 1'b1;
		end
		last_byte = b;
		kind = frame_buf[0];
		if (kind == code_rw) begin
			dec_words[0] = byte_pair(1);
			dec_words[1] = byte_pair(3);
			dec_words[2] = {8'h00, frame_buf[5]};
		end else if (kind == code_co) begin
			for (int k = 0; k < 6; k++)
				dec_words[k] = byte_pair(1 + 2 * k);
			dec_words[6] = {8'h00, frame_buf[13]};
		end else if (kind == code_st) begin
			dec_words[1] = {8'h00, frame_buf[1]};
		end else if (kind == code_th) begin
			for (int k = 0; k < 6; k++)
				dec_words[k+1] = byte_pair(1 + 2 * k);
		end
		r.words = dec_words;
		r.white = (dec_words[1] == white_st) && (dec_words[0] != white_co) && follow;
		return r;
	endfunction

	always @(posedge clk) begin : drive
		rx_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left <= 0;
		end else if (!(item_valid && item_stall)) begin
			if (item_valid)
				decoded_expect.push_back(receive_byte(rx_byte, follow_enabled));
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (byte_queue.size() > 0) begin
				nxt = byte_queue.pop_front();
				rx_byte <= nxt.data;
				follow_enabled <= nxt.follow;
				item_valid <= 1'b1;
				gap_left <= src_burst ? 0 : $urandom_range(0, 10);
				if ($urandom_range(0, 49) == 0)
					src_burst <= !src_burst;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		frame_result_t want, got;
		int hold;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			hold = stall_left;
			if (result_valid && !result_stall) begin
				got.words = {word6, word5, word4, word3, word2, word1, word0};
				got.seen = header_seen;
				got.white = white_detect;
				if (decoded_expect.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					fail_count++;
				end else begin
					want = decoded_expect.pop_front();
					for (int k = 0; k < tsfr_pkg::WORD_COUNT; k++) begin
						if (got.words[k] !== want.words[k]) begin
							$display("%0t: word%0d expected %h got %h", $time, k,
								want.words[k], got.words[k]);
							fail_count++;
						end
					end
					if (got.seen !== want.seen) begin
						$display("%0t: header_seen expected %b got %b", $time,
							want.seen, got.seen);
						fail_count++;
					end
					if (got.white !== want.white) begin
						$display("%0t: white_detect expected %b got %b", $time,
							want.white, got.white);
						fail_count++;
					end
				end
				hold = snk_burst ? 0 : $urandom_range(0, 10);
				if ($urandom_range(0, 49) == 0)
					snk_burst <= !snk_burst;
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				stall_left <= hold - 1;
			end else begin
				result_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tsfr_pkg::REG_HEADER_FIRST:   hdr_first = val[7:0];
			tsfr_pkg::REG_HEADER_SECOND:  hdr_second = val[7:0];
			tsfr_pkg::REG_CODE_STATUS:    code_st = val[7:0];
			tsfr_pkg::REG_CODE_RAW:       code_rw = val[7:0];
			tsfr_pkg::REG_CODE_THRESHOLD: code_th = val[7:0];
			tsfr_pkg::REG_CODE_COLOUR:    code_co = val[7:0];
			tsfr_pkg::REG_WHITE_STATUS:   white_st = val[15:0];
			tsfr_pkg::REG_WHITE_COLOUR:   white_co = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] h1, h2, cs, cr, ct, cc, ws, wc);
		write_reg(tsfr_pkg::REG_HEADER_FIRST, h1);
		write_reg(tsfr_pkg::REG_HEADER_SECOND, h2);
		write_reg(tsfr_pkg::REG_CODE_STATUS, cs);
		write_reg(tsfr_pkg::REG_CODE_RAW, cr);
		write_reg(tsfr_pkg::REG_CODE_THRESHOLD, ct);
		write_reg(tsfr_pkg::REG_CODE_COLOUR, cc);
		write_reg(tsfr_pkg::REG_WHITE_STATUS, ws);
		write_reg(tsfr_pkg::REG_WHITE_COLOUR, wc);
	endtask

	task automatic push_byte(input logic [7:0] b);
		rx_item_t it;
		it.data = b;
		it.follow = ($urandom_range(0, 3) != 0);
		byte_queue.push_back(it);
	endtask

	task automatic queue_traffic(input int count);
		int sel, len, p;
		logic [7:0] code;
		logic [7:0] body [13];
		while (byte_queue.size() < count) begin
			sel = $urandom_range(0, 11);
			if (sel == 0) begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
			end else begin
				foreach (body[k]) body[k] = 8'($urandom);
				case (sel % 5)
					0: begin
						code = code_st;
						len = 1;
						if ($urandom_range(0, 1)) body[0] = white_st[7:0];
					end
					1, 3: begin
						code = (sel % 5 == 1) ? code_rw : code_co;
						len = (sel % 5 == 1) ? 5 : 13;
						if ($urandom_range(0, 1)) {body[2], body[3]} = white_st;
						if ($urandom_range(0, 3) == 0) {body[0], body[1]} = white_co;
					end
					2: begin
						code = code_th;
						len = 12;
						if ($urandom_range(0, 1)) {body[0], body[1]} = white_st;
					end
					default: begin
						code = 8'($urandom);
						len = 3;
					end
				endcase
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(0, len - 1);
				if (len >= 2 && $urandom_range(0, 15) == 0) begin
					p = $urandom_range(0, len - 2);
					body[p] = hdr_first;
					body[p+1] = hdr_second;
				end
				push_byte(hdr_first);
				push_byte(hdr_second);
				push_byte(code);
				for (int k = 0; k < len; k++)
					push_byte(body[k]);
			end
		end
	endtask

	task automatic wait_drained;
		while (byte_queue.size() != 0 || item_valid || decoded_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		rx_item_t it;
		logic [7:0] codes [4];
		foreach (frame_buf[k]) frame_buf[k] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++) begin
			it.data = DIRECTED[i];
			it.follow = (i >= 2);
			byte_queue.push_back(it);
		end
		queue_traffic(200);
		wait_drained();

		set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		queue_traffic(200);
		wait_drained();

		set_all('1, '1, '1, '1, '1, '1, '1, '1);
		queue_traffic(200);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			foreach (codes[k]) codes[k] = 8'($urandom);
			if ($urandom_range(0, 2) == 0)
				codes[$urandom_range(0, 3)] = codes[$urandom_range(0, 3)];
			set_all($urandom, $urandom, {24'($urandom), codes[0]},
				{24'($urandom), codes[1]}, {24'($urandom), codes[2]},
				{24'($urandom), codes[3]},
				($urandom & 32'hFFFF_0000) | $urandom_range(0, 255), $urandom);
			queue_traffic(200);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && decoded_expect.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
